FILE: design/sobem_pkg.sv
`default_nettype none

package sobem_pkg;

  // Field and datapath widths.
  localparam int GRAY_W   = 8;
  localparam int COL_W    = 10;
  localparam int DIM_W    = 11;
  localparam int GAIN_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SUMSQ_W  = 21;
  localparam int PROD1_W  = 37;
  localparam int PROD2_W  = 53;
  localparam int SQ_W     = 54;
  localparam int ROOT_W   = 27;

  // Line geometry.
  localparam int MAX_LINE = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int MIN_DIM  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 11'd480;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd256;

  // Line buffer request: a read at the start of an item, a write in the next cycle.
  typedef struct packed {
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic [GRAY_W-1:0] wr_gray;
  } lb_req_t;

  // Line buffer read data: the pixel one row up and the pixel two rows up.
  typedef struct packed {
    logic [GRAY_W-1:0] near;
    logic [GRAY_W-1:0] far;
  } lb_rsp_t;

  // Floor of sum / 3 for sums up to 765, by multiplying with 683 / 2048.
  function automatic logic [GRAY_W-1:0] gray_of(input logic [9:0] sum);
    logic [19:0] prod;
    prod = 20'(sum) * 20'd683;
    return prod[18:11];
  endfunction

  // Clamps a frame dimension to MIN_DIM..limit.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] limit);
    logic [DIM_W-1:0] res;
    if (v < DIM_W'(MIN_DIM)) begin
      res = DIM_W'(MIN_DIM);
    end else if (v > limit) begin
      res = limit;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/sobem_line_buf.sv
`default_nettype none

module sobem_line_buf (
  input  wire logic            clk,
  input  wire sobem_pkg::lb_req_t req,
  output sobem_pkg::lb_rsp_t   rsp
);

  // Row buffers: near holds the previous row, far the row before it.
  logic [sobem_pkg::GRAY_W-1:0] mem_near [sobem_pkg::MAX_LINE];
  logic [sobem_pkg::GRAY_W-1:0] mem_far  [sobem_pkg::MAX_LINE];
  logic [sobem_pkg::GRAY_W-1:0] rd_near_r;
  logic [sobem_pkg::GRAY_W-1:0] rd_far_r;

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_near_r <= mem_near[req.rd_addr];
      rd_far_r  <= mem_far[req.rd_addr];
    end
  end

  // The write pushes the old near value down into the far row.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_near[req.wr_addr] <= req.wr_gray;
      mem_far[req.wr_addr]  <= rd_near_r;
    end
  end

  assign rsp.near = rd_near_r;
  assign rsp.far  = rd_far_r;

  // A write must follow the read of the same entry by exactly one cycle.
  a_rmw_order: assert property (@(posedge clk)
    req.wr_en |-> ($past(req.rd_en) && (req.wr_addr == $past(req.rd_addr))))
    else $error("line buffer write without matching read");

endmodule

`default_nettype wire

FILE: design/sobem_window.sv
`default_nettype none

module sobem_window (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           shift_en,
  input  wire logic [sobem_pkg::GRAY_W-1:0]   far_gray,
  input  wire logic [sobem_pkg::GRAY_W-1:0]   near_gray,
  input  wire logic [sobem_pkg::GRAY_W-1:0]   new_gray,
  input  wire logic                           grad_en,
  output logic      [sobem_pkg::SUMSQ_W-1:0]  sum_sq
);

  // win_r[row][col]: row 0 is two rows up, column 2 is the newest.
  logic [sobem_pkg::GRAY_W-1:0]  win_r [3][3];
  logic [sobem_pkg::SUMSQ_W-1:0] sum_sq_r;

  logic [9:0]  left_sum, right_sum, top_sum, bot_sum;
  logic [10:0] gx, gy;
  logic [9:0]  ax, ay;
  logic [19:0] sq_x, sq_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= far_gray;
      win_r[1][2] <= near_gray;
      win_r[2][2] <= new_gray;
    end
  end

  always_comb begin
    left_sum  = 10'(win_r[0][0]) + {1'b0, win_r[1][0], 1'b0} + 10'(win_r[2][0]);
    right_sum = 10'(win_r[0][2]) + {1'b0, win_r[1][2], 1'b0} + 10'(win_r[2][2]);
    top_sum   = 10'(win_r[0][0]) + {1'b0, win_r[0][1], 1'b0} + 10'(win_r[0][2]);
    bot_sum   = 10'(win_r[2][0]) + {1'b0, win_r[2][1], 1'b0} + 10'(win_r[2][2]);
    gx = 11'(left_sum) - 11'(right_sum);
    gy = 11'(top_sum) - 11'(bot_sum);
    ax = gx[10] ? 10'(-gx) : gx[9:0];
    ay = gy[10] ? 10'(-gy) : gy[9:0];
    sq_x = 20'(ax) * 20'(ax);
    sq_y = 20'(ay) * 20'(ay);
  end

  always_ff @(posedge clk) begin
    if (grad_en) begin
      sum_sq_r <= 21'(sq_x) + 21'(sq_y);
    end
  end

  assign sum_sq = sum_sq_r;

endmodule

`default_nettype wire

FILE: design/sobem_isqrt.sv
`default_nettype none

module sobem_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [sobem_pkg::PROD2_W-1:0] operand,
  output logic                               done,
  output logic      [sobem_pkg::ROOT_W-1:0]  root
);

  // Digit-by-digit square root, one result bit per cycle.
  logic                        busy_r;
  logic                        done_r;
  logic [sobem_pkg::SQ_W-1:0]  rem_r;
  logic [sobem_pkg::SQ_W-1:0]  root_r;
  logic [sobem_pkg::SQ_W-1:0]  bit_r;
  logic [sobem_pkg::SQ_W-1:0]  trial;

  assign trial = root_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= sobem_pkg::SQ_W'(operand);
      root_r <= '0;
      bit_r  <= sobem_pkg::SQ_W'(1) << (sobem_pkg::SQ_W - 2);
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_r  <= rem_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = root_r[sobem_pkg::ROOT_W-1:0];

  a_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> $onehot(bit_r))
    else $error("square root step bit lost");

endmodule

`default_nettype wire

FILE: design/sobel_edge_magnitude.sv
// Channel  Handshake                Payload
// in_      in_tvalid / in_tready    in_tdata: red, green, blue (8 bits each)
// out_     out_tvalid / out_tready  out_tdata: edge_level, out_col, out_row
// cfg_     cfg_valid / cfg_ready    cfg_index (register), cfg_data (value)
//
// One item is in flight at a time. A border pixel has a line buffer read, then
// a write and window shift. An interior pixel goes on to the gradient, two gain
// multiplies and a 27-step square root unit, in that order.
// The result sits in an output register, so the next item is taken while it
// waits. Reset is synchronous; the line buffers are not cleared and need no
// clearing pass. Configuration writes are always taken.
`default_nettype none

module sobel_edge_magnitude (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // edge_level [7:0], out_col [17:8], out_row [27:18]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Control sequence for one item.
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a pixel, line buffer read issued on accept
  localparam logic [2:0] ST_MEM  = 3'd1;  // read data back: write line buffers, shift window
  localparam logic [2:0] ST_GRAD = 3'd2;  // Sobel sums and sum of squares
  localparam logic [2:0] ST_MUL1 = 3'd3;  // sum of squares times gain
  localparam logic [2:0] ST_MUL2 = 3'd4;  // times gain again, square root starts
  localparam logic [2:0] ST_SQRT = 3'd5;  // square root iterating
  localparam logic [2:0] ST_OUT  = 3'd6;  // waiting for room in the output register

  logic [2:0] state_r, state_nxt;

  // Configuration registers.
  logic [sobem_pkg::DIM_W-1:0]  width_r;
  logic [sobem_pkg::DIM_W-1:0]  height_r;
  logic [sobem_pkg::GAIN_W-1:0] gain_r;

  // Raster position of the next pixel.
  logic [sobem_pkg::COL_W-1:0] col_count_r, col_count_nxt;
  logic [sobem_pkg::COL_W-1:0] row_count_r, row_count_nxt;

  // Captured per item.
  logic [sobem_pkg::COL_W-1:0]  slot_r;
  logic [sobem_pkg::GRAY_W-1:0] gray_r;
  logic [sobem_pkg::COL_W-1:0]  res_col_r;
  logic [sobem_pkg::COL_W-1:0]  res_row_r;
  logic                         has_res_r;
  logic [sobem_pkg::PROD1_W-1:0] prod1_r;

  // Output register.
  logic                         out_valid_r;
  logic [sobem_pkg::GRAY_W-1:0] out_level_r;
  logic [sobem_pkg::COL_W-1:0]  out_col_r;
  logic [sobem_pkg::COL_W-1:0]  out_row_r;

  logic                         in_accept;
  logic                         out_free;
  logic [sobem_pkg::DIM_W-1:0]  w_eff, h_eff;
  logic [sobem_pkg::DIM_W-1:0]  col_ext, row_ext, col_inc, row_inc;
  logic                         has_res_nxt;
  logic [9:0]                   chan_sum;
  logic [sobem_pkg::GRAY_W-1:0] edge_level;

  sobem_pkg::lb_req_t lb_req;
  sobem_pkg::lb_rsp_t lb_rsp;

  logic [sobem_pkg::SUMSQ_W-1:0] sum_sq;
  logic                          sq_done;
  logic [sobem_pkg::ROOT_W-1:0]  sq_root;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Configuration writes; the value is truncated to the register width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sobem_pkg::WIDTH_RST;
      height_r <= sobem_pkg::HEIGHT_RST;
      gain_r   <= sobem_pkg::GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sobem_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data[sobem_pkg::DIM_W-1:0];
        sobem_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data[sobem_pkg::DIM_W-1:0];
        sobem_pkg::CFG_GAIN:         gain_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Geometry of the current pixel. A counter beyond a newly written bound
  // simply wraps on the next pixel.
  always_comb begin
    w_eff   = sobem_pkg::clamp_dim(width_r, sobem_pkg::DIM_W'(sobem_pkg::MAX_LINE));
    h_eff   = sobem_pkg::clamp_dim(height_r, sobem_pkg::DIM_W'(sobem_pkg::MAX_ROWS));
    col_ext = sobem_pkg::DIM_W'(col_count_r);
    row_ext = sobem_pkg::DIM_W'(row_count_r);
    col_inc = col_ext + 1'b1;
    row_inc = row_ext + 1'b1;
    has_res_nxt = (col_count_r >= 10'd2) && (row_count_r >= 10'd2) &&
                  (col_ext < w_eff) && (row_ext < h_eff);
    if (col_inc >= w_eff) begin
      col_count_nxt = '0;
      row_count_nxt = (row_inc >= h_eff) ? '0 : row_inc[sobem_pkg::COL_W-1:0];
    end else begin
      col_count_nxt = col_inc[sobem_pkg::COL_W-1:0];
      row_count_nxt = row_count_r;
    end
    chan_sum = 10'(in_tdata[7:0]) + 10'(in_tdata[15:8]) + 10'(in_tdata[23:16]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      has_res_r   <= 1'b0;
    end else if (in_accept) begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
      has_res_r   <= has_res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      slot_r    <= col_count_r;
      gray_r    <= sobem_pkg::gray_of(chan_sum);
      res_col_r <= col_count_r - 1'b1;
      res_row_r <= row_count_r - 1'b1;
    end
  end

  // Line buffer: read at accept, write back the next cycle at the same slot.
  always_comb begin
    lb_req.rd_en   = in_accept;
    lb_req.rd_addr = col_count_r;
    lb_req.wr_en   = (state_r == ST_MEM);
    lb_req.wr_addr = slot_r;
    lb_req.wr_gray = gray_r;
  end

  sobem_line_buf u_line_buf (
    .clk (clk),
    .req (lb_req),
    .rsp (lb_rsp)
  );

  sobem_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (state_r == ST_MEM),
    .far_gray  (lb_rsp.far),
    .near_gray (lb_rsp.near),
    .new_gray  (gray_r),
    .grad_en   (state_r == ST_GRAD),
    .sum_sq    (sum_sq)
  );

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL1) begin
      prod1_r <= sobem_pkg::PROD1_W'(sum_sq) * sobem_pkg::PROD1_W'(gain_r);
    end
  end

  // sqrt(sum * gain^2) equals floor(gain * magnitude), so the shift by 8
  // afterwards gives the Q8.8 scaled result exactly.
  sobem_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == ST_MUL2),
    .operand (sobem_pkg::PROD2_W'(prod1_r) * sobem_pkg::PROD2_W'(gain_r)),
    .done    (sq_done),
    .root    (sq_root)
  );

  assign edge_level = (|sq_root[sobem_pkg::ROOT_W-1:16]) ? 8'hFF : sq_root[15:8];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_MEM;
      ST_MEM:  state_nxt = has_res_r ? ST_GRAD : ST_IDLE;
      ST_GRAD: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_SQRT;
      ST_SQRT: if (sq_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register: loaded when the result is ready and the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_level_r <= edge_level;
      out_col_r   <= res_col_r;
      out_row_r   <= res_row_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_row_r, out_col_r, out_level_r};

  a_res_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && has_res_nxt) |=> (state_r == ST_MEM) ##1 (state_r == ST_GRAD))
    else $error("interior pixel did not enter the gradient stage");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result appeared outside the output stage");

endmodule

`default_nettype wire

FILE: tb/sobel_edge_magnitude_tb.sv
module sobel_edge_magnitude_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sobem_pkg::*;

  // Clock, reset and pacing.
  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int MAX_IDLE      = 18;
  // An interior pixel keeps the block busy through its square root. A border pixel
  // gives no result, so an empty result queue does not prove the block is idle.
  // This margin covers the longest pixel before a register write.
  localparam int DRAIN_CYCLES  = 48;
  // The longest quiet stretch in a correct run is a sender gap, a full interior
  // pixel, a receiver stall and the drain margin. The limit is many times that.
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_PIXELS = 400;
  localparam int REPORT_LIMIT  = 10;

  // The expected result of one centre pixel, laid out as in out_tdata[27:0].
  typedef struct packed {
    logic [COL_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [GRAY_W-1:0] level;
  } edge_res_t;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

  // One row of the directed stimulus table.
  typedef struct {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [15:0]          value;
    logic [23:0]          rgb;
    bit                   typed;
    edge_res_t            want;
  } plan_step_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata   = '0;   // red [7:0], green [15:8], blue [23:16]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;         // edge_level [7:0], out_col [17:8], out_row [27:18]
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [15:0]          cfg_data   = '0;

  sobel_edge_magnitude dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Shadow copy of the block: registers, the two line stores, the 3x3 window
  // and the position of the next pixel in the frame.
  logic [DIM_W-1:0]  width_reg  = WIDTH_RST;
  logic [DIM_W-1:0]  height_reg = HEIGHT_RST;
  logic [GAIN_W-1:0] gain_reg   = GAIN_RST;
  int                gray_up1 [MAX_LINE] = '{default: 0};
  int                gray_up2 [MAX_LINE] = '{default: 0};
  int                pix_win [3][3] = '{default: 0};
  int unsigned       col_at = 0;
  int unsigned       row_at = 0;

  // Results still owed by the block, oldest first.
  edge_res_t pending_edges [$];
  plan_step_t directed_plan [$];

  int mismatches    = 0;
  int pixels_sent   = 0;
  int edges_checked = 0;
  int writes_done   = 0;
  int frames_run    = 0;
  int mid_writes    = 0;
  int quiet_cycles  = 0;
  int burst_in      = 0;
  int burst_out     = 0;

  // Content of the frame being sent.
  int paint_style, tone_base, tone_high, tone_dx, tone_dy, split_col;

  function automatic void note_error(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("MISMATCH: %s", msg);
    end
  endfunction

  function automatic int unsigned clamped(input int unsigned v, input int unsigned hi);
    if (v < MIN_DIM) begin
      return MIN_DIM;
    end
    return (v > hi) ? hi : v;
  endfunction

  // Bitwise integer square root; the argument stays below 2**54.
  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] root, trial;
    root = '0;
    for (int b = 27; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Advances the shadow state by one pixel and reports whether a result is due.
  function automatic bit predict_pixel(input logic [23:0] rgb, output edge_res_t res);
    int unsigned w_eff, h_eff, col, row, slot;
    int gray, up1, up2, gx, gy;
    logic [63:0] energy, root;
    bit fired;
    w_eff = clamped(width_reg, MAX_LINE);
    h_eff = clamped(height_reg, MAX_ROWS);
    col = col_at;
    row = row_at;
    gray = (32'(rgb[7:0]) + 32'(rgb[15:8]) + 32'(rgb[23:16])) / 3;
    slot = col % MAX_LINE;
    up1 = gray_up1[slot];
    up2 = gray_up2[slot];
    gray_up2[slot] = up1;
    gray_up1[slot] = gray;
    for (int r = 0; r < 3; r++) begin
      pix_win[r][0] = pix_win[r][1];
      pix_win[r][1] = pix_win[r][2];
    end
    pix_win[0][2] = up2;
    pix_win[1][2] = up1;
    pix_win[2][2] = gray;
    res = '0;
    fired = 1'b0;
    if (col >= 2 && row >= 2 && col < w_eff && row < h_eff) begin
      gx = (pix_win[0][0] + 2 * pix_win[1][0] + pix_win[2][0])
         - (pix_win[0][2] + 2 * pix_win[1][2] + pix_win[2][2]);
      gy = (pix_win[0][0] + 2 * pix_win[0][1] + pix_win[0][2])
         - (pix_win[2][0] + 2 * pix_win[2][1] + pix_win[2][2]);
      energy = 64'(gx * gx + gy * gy);
      root = floor_root(energy * gain_reg * gain_reg) >> 8;
      res.level = (root > 255) ? 8'hFF : root[7:0];
      res.col = COL_W'(col - 1);
      res.row = COL_W'(row - 1);
      fired = 1'b1;
    end
    if (col + 1 >= w_eff) begin
      col_at = 0;
      row_at = (row + 1 >= h_eff) ? 0 : row + 1;
    end else begin
      col_at = col + 1;
    end
    return fired;
  endfunction

  // Wait before the next item: mostly random, sometimes a run of back-to-back items.
  function automatic int draw_wait(inout int burst);
    int n;
    n = 0;
    if (burst > 0) begin
      burst--;
    end else if ($urandom_range(0, 11) == 0) begin
      burst = $urandom_range(8, 40);
    end else begin
      n = $urandom_range(0, MAX_IDLE);
    end
    return n;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return GAIN_RST;
      1:       return GAIN_W'($urandom_range(0, 65535));
      2:       return GAIN_W'($urandom_range(0, 600));
      3:       return ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
      default: return GAIN_W'($urandom_range(128, 384));
    endcase
  endfunction

  function automatic logic [7:0] sat8(input int v);
    if (v < 0) begin
      return 8'd0;
    end
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  // Pixel at (c, r) of the current frame: pure noise, a ramp or a vertical step,
  // the last two with a little noise per channel.
  function automatic logic [23:0] paint(input int c, input int r);
    int v;
    logic [7:0] chan [3];
    case (paint_style)
      0:       return 24'($urandom);
      1:       v = tone_base + tone_dx * c + tone_dy * r;
      default: v = (c >= split_col) ? tone_high : tone_base;
    endcase
    for (int k = 0; k < 3; k++) begin
      chan[k] = sat8(v + int'($urandom_range(0, 6)) - 3);
    end
    return {chan[2], chan[1], chan[0]};
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    plan_step_t s;
    s.kind = STEP_WRITE;
    s.reg_idx = idx;
    s.value = value;
    s.rgb = '0;
    s.typed = 1'b0;
    s.want = '0;
    directed_plan.push_back(s);
  endfunction

  function automatic void add_pixel(input logic [7:0] red, input logic [7:0] green,
                                    input logic [7:0] blue);
    plan_step_t s;
    s.kind = STEP_PIXEL;
    s.reg_idx = '0;
    s.value = '0;
    s.rgb = {blue, green, red};
    s.typed = 1'b0;
    s.want = '0;
    directed_plan.push_back(s);
  endfunction

  // A pixel that closes a 3x3 frame; its result belongs to the centre (1, 1).
  function automatic void add_checked(input logic [7:0] red, input logic [7:0] green,
                                      input logic [7:0] blue, input logic [7:0] level);
    plan_step_t s;
    s.kind = STEP_PIXEL;
    s.reg_idx = '0;
    s.value = '0;
    s.rgb = {blue, green, red};
    s.typed = 1'b1;
    s.want = {10'd1, 10'd1, level};
    directed_plan.push_back(s);
  endfunction

  // Sends one pixel. Valid stays high across back-to-back items; the
  // expectation is recorded at the edge where the pixel is taken.
  task automatic send_pixel(input logic [23:0] rgb, input bit typed, input edge_res_t want);
    int gap;
    bit fired;
    edge_res_t res;
    gap = draw_wait(burst_in);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= rgb;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fired = predict_pixel(rgb, res);
    if (typed) begin
      pending_edges.push_back(want);
    end else if (fired) begin
      pending_edges.push_back(res);
    end
    pixels_sent++;
  endtask

  // Holds the input back until every owed result has come out, then lets a
  // border pixel still in flight finish.
  task automatic settle_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg = value[DIM_W-1:0];
      CFG_IMAGE_HEIGHT: height_reg = value[DIM_W-1:0];
      CFG_GAIN:         gain_reg = value;
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Programs a new geometry and gain at a frame boundary and picks the content.
  // The spare upper bits of the dimension writes carry noise; the block keeps 11.
  task automatic setup_frame(input int raw_w, input int raw_h);
    write_reg(CFG_IMAGE_WIDTH, {5'($urandom), 11'(raw_w)});
    write_reg(CFG_IMAGE_HEIGHT, {5'($urandom), 11'(raw_h)});
    write_reg(CFG_GAIN, pick_gain());
    paint_style = $urandom_range(0, 2);
    tone_base = $urandom_range(0, 255);
    tone_high = $urandom_range(0, 255);
    tone_dx = int'($urandom_range(0, 40)) - 20;
    tone_dy = int'($urandom_range(0, 40)) - 20;
    split_col = $urandom_range(0, clamped(width_reg, MAX_LINE));
  endtask

  // Sends pixels until the frame position is back at the origin. At pixel
  // change_at (if not negative) one register is rewritten in mid-frame: the
  // gain, the height, or a narrower width. The width never grows mid-frame,
  // so every result window reads line store entries written earlier.
  task automatic feed_frame(input int change_at);
    int count;
    count = 0;
    do begin
      if (count == change_at) begin
        case ($urandom_range(0, 2))
          0: write_reg(CFG_GAIN, pick_gain());
          1: write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(0, 10)));
          default: write_reg(CFG_IMAGE_WIDTH,
                             16'($urandom_range(0, clamped(width_reg, MAX_LINE))));
        endcase
        mid_writes++;
      end
      send_pixel(paint(col_at, row_at), 1'b0, '0);
      count++;
      if ($urandom_range(0, 79) == 0) begin
        settle_idle();
      end
    end while (col_at != 0 || row_at != 0);
    frames_run++;
  endtask

  // Result side: a random stall before each item, with stall-free runs.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(burst_out);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Every result taken is compared with the oldest expectation.
  always @(posedge clk) begin
    edge_res_t want;
    edge_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[27:0];
      if (pending_edges.size() == 0) begin
        note_error($sformatf("result with none owed: level %0d col %0d row %0d",
                             got.level, got.col, got.row));
      end else begin
        want = pending_edges.pop_front();
        if (got !== want || out_tdata[31:28] !== 4'd0) begin
          note_error($sformatf(
            "result %0d: level %0d/%0d col %0d/%0d row %0d/%0d pad %h (expected/actual)",
            edges_checked, want.level, got.level, want.col, got.col, want.row, got.row,
            out_tdata[31:28]));
        end
        edges_checked++;
      end
    end
  end

  // Watchdog: ends the run when no channel has moved an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: %0d cycles without an item, %0d results still owed",
                 QUIET_LIMIT, pending_edges.size());
        $display("sobel_edge_magnitude_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int random_goal;
    // Directed table. All frames are 3x3; the widths and heights written here
    // lie below the minimum and are clamped up to 3.
    add_write(CFG_IMAGE_WIDTH, 16'd0);
    add_write(CFG_IMAGE_HEIGHT, 16'd2);
    add_write(CFG_GAIN, 16'd256);
    // A white left column on black: the horizontal sum is 1020 at unit gain,
    // so the level saturates.
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_checked(8'd0, 8'd0, 8'd0, 8'd255);
    // Zero gain wipes out any gradient; the channels run through their extremes.
    add_write(CFG_GAIN, 16'd0);
    add_pixel(8'd255, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd255, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd255);
    add_pixel(8'd255, 8'd255, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd1, 8'd2, 8'd3);
    add_pixel(8'd128, 8'd64, 8'd32);
    add_checked(8'd254, 8'd254, 8'd254, 8'd0);
    // A faint left column with the largest gain, written in the middle of the
    // frame: a sum of 12 scaled by almost 256 saturates.
    add_pixel(8'd3, 8'd3, 8'd3);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd3, 8'd3, 8'd3);
    add_write(CFG_GAIN, 16'hFFFF);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd3, 8'd3, 8'd3);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_checked(8'd0, 8'd0, 8'd0, 8'd255);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == STEP_WRITE) begin
        write_reg(directed_plan[i].reg_idx, directed_plan[i].value);
      end else begin
        send_pixel(directed_plan[i].rgb, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // Random frames, mostly small, some with a register rewritten mid-frame.
    random_goal = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < random_goal) begin
      setup_frame(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) :
                  $urandom_range(3, ($urandom_range(0, 5) == 0) ? 40 : 12),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7));
      feed_frame(($urandom_range(0, 3) == 0) ?
                 $urandom_range(1, clamped(width_reg, MAX_LINE) *
                                   clamped(height_reg, MAX_ROWS) - 1) : -1);
    end

    // The all-ones geometry clamps to 1024 by 1024. A stretch of the first row
    // goes out at full width, then the frame shrinks to 3x3, so the column
    // counter sits beyond its new bound and wraps on the next pixel.
    setup_frame(2047, 2047);
    repeat (24) send_pixel(paint(col_at, row_at), 1'b0, '0);
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    write_reg(CFG_IMAGE_WIDTH, 16'd3);
    mid_writes += 2;
    feed_frame(-1);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d pixels in %0d frames, %0d register writes (%0d mid-frame)",
             pixels_sent, frames_run, writes_done, mid_writes);
    $display("checked %0d edge levels, geometries from clamped-low to clamped-high",
             edges_checked);
    if (mismatches == 0) begin
      $display("sobel_edge_magnitude_tb: done, clean");
    end else begin
      $display("sobel_edge_magnitude_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/sobem_pkg.sv
design/sobem_line_buf.sv
design/sobem_window.sv
design/sobem_isqrt.sv
design/sobel_edge_magnitude.sv
tb/sobel_edge_magnitude_tb.sv
